>>> sv/point_box_signed_distance_top_macros.svh
// Assertion macros shared by the point-to-box distance RTL.
// Included by every module that carries concurrent assertions.
`ifndef POINT_BOX_SIGNED_DISTANCE_TOP_MACROS_SVH
`define POINT_BOX_SIGNED_DISTANCE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBSD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBSD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/pbsd_pkg.sv
// Shared types and sizing constants for the point-to-box distance pipeline.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package pbsd_pkg;

   localparam int DIMENSION    = 3;
   localparam int COORD_BITS   = 24;
   localparam int SD_BITS      = 26;
   localparam int AXES         = 3;
   localparam int SQ_BITS      = 2 * COORD_BITS;
   localparam int SUM_BITS     = SQ_BITS + 2;
   localparam int ROOT_BITS    = SUM_BITS / 2;
   localparam int REM_BITS     = ROOT_BITS + 3;
   localparam int FRONT_STAGES = 3;
   localparam int PIPE_STAGES  = FRONT_STAGES + ROOT_BITS + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      coord_type box_min_x;
      coord_type box_min_y;
      coord_type box_min_z;
      coord_type box_max_x;
      coord_type box_max_y;
      coord_type box_max_z;
   } req_type;

   typedef struct packed {
      logic signed [SD_BITS-1:0] signed_distance;
      logic                      inside_res;
   } rsp_type;

   // Per-axis result of the range test.
   typedef struct packed {
      logic                  outside;
      logic [COORD_BITS-1:0] excess;
      logic [COORD_BITS-1:0] to_lo;
      logic [COORD_BITS-1:0] to_hi;
   } axis_type;

   // Work carried through the square root stages.
   typedef struct packed {
      logic [SUM_BITS-1:0]   radicand;
      logic [REM_BITS-1:0]   rem;
      logic [ROOT_BITS-1:0]  root;
      logic                  in_box;
      logic [COORD_BITS-1:0] near;
   } root_type;

endpackage

>>> sv/point_box_signed_distance_top.sv
// Signed distance from a point to an axis-aligned box, Q12.12 in, Q14.12 out.
// Depends on pbsd_pkg, pbsd_front, pbsd_root_step and the assertion macro header.
`timescale 1ns / 1ps
`include "point_box_signed_distance_top_macros.svh"

// The block takes one item per clock while req_ready is high and passes it through 29
// register stages: three front stages (range test, squares with the face minimum, sum of
// squares), 25 square root stages that each settle one root bit with one 28-bit compare
// and subtract, and the output register. Every stage holds its item when it is full and
// the next one does not load, so a stalled output fills the bubbles upstream before
// req_ready drops. Outside the box the result is the floored Euclidean distance and
// inside_res is 0; inside, faces included, it is minus the distance to the nearest face
// and inside_res is 1.
module point_box_signed_distance_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pbsd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pbsd_pkg::rsp_type rsp_data
);
   import pbsd_pkg::*;

   logic [PIPE_STAGES-1:0] stage_valid;
   logic [PIPE_STAGES-1:0] load;

   logic     root_valid [ROOT_BITS+1];
   root_type root_data  [ROOT_BITS+1];

   logic    rsp_valid_ff;
   rsp_type rsp_in, rsp_ff;

   // A stage loads when it is empty or when the stage after it loads.
   always_comb begin
      load[PIPE_STAGES-1] = !stage_valid[PIPE_STAGES-1] || rsp_ready;
      for (int s = PIPE_STAGES - 2; s >= 0; s--) begin
         load[s] = !stage_valid[s] || load[s+1];
      end
   end

   assign req_ready = load[0];

   pbsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .load      (load[FRONT_STAGES-1:0]),
      .req_valid (req_valid),
      .req_data  (req_data),
      .valid     (stage_valid[FRONT_STAGES-1:0]),
      .root_data (root_data[0])
   );

   assign root_valid[0] = stage_valid[FRONT_STAGES-1];

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
      pbsd_root_step u_step (
         .clock     (clock),
         .reset     (reset),
         .load      (load[FRONT_STAGES+k]),
         .in_valid  (root_valid[k]),
         .in_data   (root_data[k]),
         .out_valid (root_valid[k+1]),
         .out_data  (root_data[k+1])
      );
      assign stage_valid[FRONT_STAGES+k] = root_valid[k+1];
   end

   always_comb begin
      rsp_in.inside_res = root_data[ROOT_BITS].in_box;
      if (root_data[ROOT_BITS].in_box) begin
         rsp_in.signed_distance = SD_BITS'(0) - SD_BITS'(root_data[ROOT_BITS].near);
      end else begin
         rsp_in.signed_distance = SD_BITS'(root_data[ROOT_BITS].root);
      end
   end

   always_ff @(posedge clock) begin
      if (load[PIPE_STAGES-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load[PIPE_STAGES-1]) begin
         rsp_valid_ff <= root_valid[ROOT_BITS];
      end
   end

   assign stage_valid[PIPE_STAGES-1] = rsp_valid_ff;
   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_data                   = rsp_ff;

   `PBSD_ASSERT_IMP(a_empty_out_ready, clock, reset,
      !rsp_valid_ff, req_ready,
      "input is refused although the output register is empty")
   `PBSD_ASSERT_IMP(a_inside_not_positive, clock, reset,
      rsp_valid_ff && rsp_ff.inside_res,
      rsp_ff.signed_distance[SD_BITS-1] || (rsp_ff.signed_distance == '0),
      "inside result has a positive distance")
   `PBSD_ASSERT_NXT(a_accept_enters, clock, reset,
      req_valid && req_ready, stage_valid[0],
      "accepted item did not enter the first stage")

endmodule

>>> sv/pbsd_front.sv
// Front stages: per-axis range test, squares and face minimum, sum of squares.
// Depends on pbsd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "point_box_signed_distance_top_macros.svh"

module pbsd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pbsd_pkg::FRONT_STAGES-1:0]   load,
   input  logic                                req_valid,
   input  pbsd_pkg::req_type                   req_data,
   output logic [pbsd_pkg::FRONT_STAGES-1:0]   valid,
   output pbsd_pkg::root_type                  root_data
);
   import pbsd_pkg::*;

   coord_type pnt  [AXES];
   coord_type bmin [AXES];
   coord_type bmax [AXES];

   logic signed [COORD_BITS:0] diff_lo [AXES];
   logic signed [COORD_BITS:0] diff_hi [AXES];

   axis_type axis_in [AXES];
   axis_type axis_ff [AXES];

   logic [SQ_BITS-1:0]    sq_in [AXES];
   logic [SQ_BITS-1:0]    sq_ff [AXES];
   logic                  inside2_in, inside2_ff;
   logic [COORD_BITS-1:0] near2_in, near2_ff;

   logic [SUM_BITS-1:0]   sum_in, sum_ff;
   logic                  inside3_ff;
   logic [COORD_BITS-1:0] near3_ff;

   logic [FRONT_STAGES-1:0] valid_ff, valid_in;

   assign pnt[0]  = req_data.point_x;
   assign pnt[1]  = req_data.point_y;
   assign pnt[2]  = req_data.point_z;
   assign bmin[0] = req_data.box_min_x;
   assign bmin[1] = req_data.box_min_y;
   assign bmin[2] = req_data.box_min_z;
   assign bmax[0] = req_data.box_max_x;
   assign bmax[1] = req_data.box_max_y;
   assign bmax[2] = req_data.box_max_z;

   // Stage 1: the below test wins over the above test, as for an inverted box.
   for (genvar c = 0; c < AXES; c++) begin : g_axis
      assign diff_lo[c] = (COORD_BITS+1)'(pnt[c]) - (COORD_BITS+1)'(bmin[c]);
      assign diff_hi[c] = (COORD_BITS+1)'(bmax[c]) - (COORD_BITS+1)'(pnt[c]);

      always_comb begin
         axis_in[c].to_lo   = diff_lo[c][COORD_BITS-1:0];
         axis_in[c].to_hi   = diff_hi[c][COORD_BITS-1:0];
         axis_in[c].outside = 1'b0;
         axis_in[c].excess  = '0;
         if (c >= DIMENSION) begin
            // An unused axis never wins the face minimum.
            axis_in[c].to_lo = '1;
            axis_in[c].to_hi = '1;
         end else if (diff_lo[c][COORD_BITS]) begin
            axis_in[c].outside = 1'b1;
            axis_in[c].excess  = COORD_BITS'(-diff_lo[c]);
         end else if (diff_hi[c][COORD_BITS]) begin
            axis_in[c].outside = 1'b1;
            axis_in[c].excess  = COORD_BITS'(-diff_hi[c]);
         end
      end

      assign sq_in[c] = axis_ff[c].excess * axis_ff[c].excess;

      always_ff @(posedge clock) begin
         if (load[0]) begin
            axis_ff[c] <= axis_in[c];
         end
         if (load[1]) begin
            sq_ff[c] <= sq_in[c];
         end
      end
   end

   // Stage 2: the face distances are only meaningful when every axis is in range.
   always_comb begin
      inside2_in = 1'b1;
      near2_in   = '1;
      for (int c = 0; c < AXES; c++) begin
         if (axis_ff[c].outside) begin
            inside2_in = 1'b0;
         end
         if (axis_ff[c].to_lo < near2_in) begin
            near2_in = axis_ff[c].to_lo;
         end
         if (axis_ff[c].to_hi < near2_in) begin
            near2_in = axis_ff[c].to_hi;
         end
      end
   end

   // Stage 3: sum of squared excesses.
   always_comb begin
      sum_in = '0;
      for (int c = 0; c < AXES; c++) begin
         sum_in = sum_in + SUM_BITS'(sq_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         inside2_ff <= inside2_in;
         near2_ff   <= near2_in;
      end
      if (load[2]) begin
         sum_ff     <= sum_in;
         inside3_ff <= inside2_ff;
         near3_ff   <= near2_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int s = 1; s < FRONT_STAGES; s++) begin
         if (load[s]) begin
            valid_in[s] = valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign valid              = valid_ff;
   assign root_data.radicand = sum_ff;
   assign root_data.rem      = '0;
   assign root_data.root     = '0;
   assign root_data.in_box   = inside3_ff;
   assign root_data.near     = near3_ff;

   `PBSD_ASSERT_IMP(a_inside_no_excess, clock, reset,
      valid_ff[FRONT_STAGES-1] && inside3_ff, sum_ff == '0,
      "inside item carries a nonzero sum of squares")

endmodule

>>> sv/pbsd_root_step.sv
// One stage of the restoring square root: retires one root bit per cycle when its load is high.
// Depends on pbsd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "point_box_signed_distance_top_macros.svh"

module pbsd_root_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic               in_valid,
   input  pbsd_pkg::root_type in_data,
   output logic               out_valid,
   output pbsd_pkg::root_type out_data
);
   import pbsd_pkg::*;

   logic [REM_BITS-1:0] rem_shift;
   logic [REM_BITS-1:0] trial;
   root_type            step_in, step_ff;
   logic                valid_ff;

   // Bring down the next two radicand bits and try appending a one to the root.
   always_comb begin
      rem_shift        = {in_data.rem[REM_BITS-3:0], in_data.radicand[SUM_BITS-1 -: 2]};
      trial            = REM_BITS'({in_data.root, 2'b01});
      step_in          = in_data;
      step_in.radicand = in_data.radicand << 2;
      if (rem_shift >= trial) begin
         step_in.rem  = rem_shift - trial;
         step_in.root = {in_data.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         step_in.rem  = rem_shift;
         step_in.root = {in_data.root[ROOT_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = step_ff;

   `PBSD_ASSERT_IMP(a_rem_bound, clock, reset,
      valid_ff, step_ff.rem <= (REM_BITS'(step_ff.root) << 1),
      "square root remainder exceeds twice the partial root")

endmodule
